/* hdl/nfvs_pkg.sv */
// shared types, constants and defaults for the nearest free voxel snap block
`timescale 1ns / 1ps

package nfvs_pkg;

	// field widths
	localparam int COORD_W  = 7;
	localparam int SUM_W    = COORD_W + 1;
	localparam int RADIUS_W = 3;
	localparam int STATUS_W = 2;

	// parameter defaults
	localparam int GRID_X_DEF     = 32;
	localparam int GRID_Y_DEF     = 32;
	localparam int GRID_Z_DEF     = 32;
	localparam int MAX_RADIUS_DEF = 7;

	// reset value of the search radius register
	localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);

	// request kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_SNAP  = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_KEEP  = 2'd0,
		STAT_MOVED = 2'd1,
		STAT_NONE  = 2'd2,
		STAT_WRITE = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_ROW,
		ST_WR_BACK,
		ST_CENTER,
		ST_SCAN,
		ST_FLUSH,
		ST_RESP
	} state_t;

endpackage

/* hdl/nfvs_map.sv */
// occupancy row memory with a clearing sweep after reset
`timescale 1ns / 1ps

module nfvs_map
	import nfvs_pkg::*;
#(
	parameter int AW     = 10,
	parameter int DATA_W = GRID_Z_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic              clr_busy
);

	localparam int DEPTH = 1 << AW;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [AW-1:0]     clr_addr_q;
	logic              clr_busy_q;

	// clearing sweep, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == {AW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// write port, the sweep has priority
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

endmodule

/* hdl/nearest_free_voxel_snap.sv */
// nearest free voxel snap: occupancy map writes and nearest free cell search
//
// channel   signals                                        direction
// request   in_valid in_ready action cell_x/y/z block_bit  in
// result    out_valid out_ready out_x/y/z status           out
// config    cfg_wr_en cfg_wr_data (search radius)          in
//
// write or snap with no search: ST_RD_ROW, then ST_WR_BACK or ST_CENTER, then ST_RESP loads the result
// searching snap: ST_RD_ROW, ST_CENTER, then one occupancy bit per cycle in ST_SCAN, then ST_FLUSH
// and ST_RESP; ST_RESP waits while the output register is full and out_ready is low
// after reset the map is cleared one row per cycle, all 2^(clog2(GRID_X)+clog2(GRID_Y)) rows
// (1024 at the defaults), with in_ready low
// one request at a time; a new one is accepted while a result waits in the output register
`timescale 1ns / 1ps

module nearest_free_voxel_snap
	import nfvs_pkg::*;
#(
	parameter int GRID_X     = GRID_X_DEF,
	parameter int GRID_Y     = GRID_Y_DEF,
	parameter int GRID_Z     = GRID_Z_DEF,
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [RADIUS_W-1:0]       cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic signed [COORD_W-1:0] cell_x,
	input  logic signed [COORD_W-1:0] cell_y,
	input  logic signed [COORD_W-1:0] cell_z,
	input  logic                      block_bit,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] out_x,
	output logic signed [COORD_W-1:0] out_y,
	output logic signed [COORD_W-1:0] out_z,
	output logic [STATUS_W-1:0]       status
);

	localparam int XW = $clog2(GRID_X);
	localparam int YW = $clog2(GRID_Y);
	localparam int ZW = $clog2(GRID_Z);
	localparam int AW = XW + YW;
	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int DW = $clog2(3 * MAX_RADIUS + 1);

	state_t state_q, next_state;

	logic [RADIUS_W-1:0]       radius_q;
	logic [RW-1:0]             r_eff;
	logic [RW-1:0]             r_q;
	logic signed [RW:0]        r_s;
	logic                      act_q;
	logic                      blk_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic signed [RW:0]        dx_q, dy_q, dz_q;
	logic                      scan_q;
	logic                      found_q;
	logic [DW-1:0]             best_d_q;
	logic [COORD_W-1:0]        best_x_q, best_y_q, best_z_q;

	logic signed [SUM_W-1:0]   px, py, pz;
	logic                      probe_inb;
	logic [DW-1:0]             probe_d;
	logic                      scan_last;

	logic                      valid_s1;
	logic                      inb_s1;
	logic [ZW-1:0]             zi_s1;
	logic [DW-1:0]             d_s1;
	logic [COORD_W-1:0]        px_s1, py_s1, pz_s1;
	logic                      probe_free;

	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic [GRID_Z-1:0]         rd_row;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [GRID_Z-1:0]         wr_row;
	logic                      clr_busy;

	logic                      out_load;
	logic                      out_valid_q;
	logic [COORD_W-1:0]        out_x_q, out_y_q, out_z_q;
	logic [STATUS_W-1:0]       status_q;
	status_t                   res_status;

	function automatic logic in_range(input logic signed [SUM_W-1:0] v, input int lim);
		return !v[SUM_W-1] && ($unsigned(v) < SUM_W'(lim));
	endfunction

	function automatic logic [RW-1:0] mag(input logic signed [RW:0] d);
		logic signed [RW:0] n;
		n = -d;
		return d[RW] ? n[RW-1:0] : d[RW-1:0];
	endfunction

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	// radius clamp
	always_comb begin
		if (int'(radius_q) > MAX_RADIUS) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(radius_q);
		end
	end

	assign r_s       = $signed({1'b0, r_q});
	assign in_ready  = (state_q == ST_IDLE) && !clr_busy;
	assign scan_last = (dx_q == r_s) && (dy_q == r_s) && (dz_q == r_s);

	// probe coordinate: the request cell, plus the offset while scanning
	always_comb begin
		px = SUM_W'(cx_q);
		py = SUM_W'(cy_q);
		pz = SUM_W'(cz_q);
		if (state_q == ST_SCAN) begin
			px = SUM_W'(cx_q) + SUM_W'(dx_q);
			py = SUM_W'(cy_q) + SUM_W'(dy_q);
			pz = SUM_W'(cz_q) + SUM_W'(dz_q);
		end
	end

	assign probe_inb = in_range(px, GRID_X) && in_range(py, GRID_Y) && in_range(pz, GRID_Z);
	assign probe_d   = DW'(mag(dx_q)) + DW'(mag(dy_q)) + DW'(mag(dz_q));
	assign rd_addr   = {px[XW-1:0], py[YW-1:0]};

	// next state
	always_comb begin
		next_state = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					next_state = ST_RD_ROW;
				end
			end
			ST_RD_ROW: begin
				next_state = (act_q == ACT_WRITE) ? ST_WR_BACK : ST_CENTER;
			end
			ST_WR_BACK: begin
				next_state = ST_RESP;
			end
			ST_CENTER: begin
				next_state = (probe_free || (r_q == '0)) ? ST_RESP : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) begin
					next_state = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				next_state = ST_RESP;
			end
			ST_RESP: begin
				if (out_load) begin
					next_state = ST_IDLE;
				end
			end
			default: begin
				next_state = ST_IDLE;
			end
		endcase
	end

	// memory controls and result status
	always_comb begin
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		out_load   = 1'b0;
		res_status = STAT_KEEP;
		case (state_q)
			ST_RD_ROW:  rd_en = 1'b1;
			ST_SCAN:    rd_en = 1'b1;
			ST_WR_BACK: wr_en = inb_s1;
			ST_RESP:    out_load = !out_valid_q || out_ready;
			default:    rd_en = 1'b0;
		endcase
		if (act_q == ACT_WRITE) begin
			res_status = STAT_WRITE;
		end else if (scan_q) begin
			res_status = found_q ? STAT_MOVED : STAT_NONE;
		end
	end

	// row update for a write
	always_comb begin
		wr_row            = rd_row;
		wr_row[zi_s1]     = blk_q;
	end

	assign wr_addr    = {cx_q[XW-1:0], cy_q[YW-1:0]};
	assign probe_free = inb_s1 && !rd_row[zi_s1];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= next_state;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= action;
			blk_q <= block_bit;
			cx_q  <= cell_x;
			cy_q  <= cell_y;
			cz_q  <= cell_z;
			r_q   <= r_eff;
		end
	end

	// probe stage alongside the memory read
	always_ff @(posedge clk) begin
		inb_s1 <= probe_inb;
		zi_s1  <= pz[ZW-1:0];
		d_s1   <= probe_d;
		px_s1  <= px[COORD_W-1:0];
		py_s1  <= py[COORD_W-1:0];
		pz_s1  <= pz[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
		end
	end

	// offset counters, x outermost and z innermost
	always_ff @(posedge clk) begin
		if (state_q == ST_CENTER) begin
			dx_q <= -r_s;
			dy_q <= -r_s;
			dz_q <= -r_s;
		end else if (state_q == ST_SCAN) begin
			if (dz_q != r_s) begin
				dz_q <= dz_q + (RW + 1)'(1);
			end else begin
				dz_q <= -r_s;
				if (dy_q != r_s) begin
					dy_q <= dy_q + (RW + 1)'(1);
				end else begin
					dy_q <= -r_s;
					dx_q <= dx_q + (RW + 1)'(1);
				end
			end
		end
	end

	// search bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				scan_q  <= 1'b0;
				found_q <= 1'b0;
			end else begin
				if ((state_q == ST_CENTER) && !probe_free && (r_q != '0)) begin
					scan_q <= 1'b1;
				end
				if (valid_s1 && probe_free) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// best candidate, strict compare keeps the first one scanned
	always_ff @(posedge clk) begin
		if (valid_s1 && probe_free && (!found_q || (d_s1 < best_d_q))) begin
			best_d_q <= d_s1;
			best_x_q <= px_s1;
			best_y_q <= py_s1;
			best_z_q <= pz_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= res_status;
			if (scan_q && found_q) begin
				out_x_q <= best_x_q;
				out_y_q <= best_y_q;
				out_z_q <= best_z_q;
			end else begin
				out_x_q <= cx_q;
				out_y_q <= cy_q;
				out_z_q <= cz_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign status    = status_q;

	// occupancy memory
	nfvs_map #(
		.AW     (AW),
		.DATA_W (GRID_Z)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_row),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_row),
		.clr_busy (clr_busy)
	);

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted request did not start work");

	a_probe_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SCAN) || (state_q == ST_FLUSH))
		else $error("scan probe outside the scan");

	a_write_only_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_WR_BACK) && (act_q == ACT_WRITE))
		else $error("map write outside a write request");

	a_moved_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (res_status == STAT_MOVED) |->
			!best_x_q[COORD_W-1] && !best_y_q[COORD_W-1] && !best_z_q[COORD_W-1])
		else $error("moved result outside the grid");

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ready)
		else $error("request taken during the clearing sweep");
`endif

endmodule

/* tb/sv/nearest_free_voxel_snap_test.sv */
// self-checking testbench for the nearest free voxel snap block
`timescale 1ns / 1ps

module nearest_free_voxel_snap_test;
	import nfvs_pkg::*;

	localparam int VOXELS  = GRID_X_DEF * GRID_Y_DEF * GRID_Z_DEF;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic                      act;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      blk;
	} voxel_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		status_t                   st;
	} voxel_res_t;

	// block ports
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [RADIUS_W-1:0]       cfg_wr_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      action = ACT_WRITE;
	logic signed [COORD_W-1:0] cell_x = '0;
	logic signed [COORD_W-1:0] cell_y = '0;
	logic signed [COORD_W-1:0] cell_z = '0;
	logic                      block_bit = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;
	logic [STATUS_W-1:0]       status;

	// mirror of the block state
	bit                  occ_map [VOXELS];
	logic [RADIUS_W-1:0] snap_radius = RADIUS_RST;

	// request and result bookkeeping
	voxel_req_t pending_q [$];
	voxel_res_t expect_q [$];
	int         mismatch_total = 0;
	int         queued_total = 0;
	int         phase_count = 0;
	int         status_seen [4] = '{0, 0, 0, 0};

	// idling controls; no_gaps and hold_arm change at the falling edge, hold_left and hold_done at the rising
	bit no_gaps = 1'b0;
	bit hold_arm = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	nearest_free_voxel_snap uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_z     (cell_z),
		.block_bit  (block_bit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.status     (status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// grid lookups
	function automatic bit on_grid(int x, int y, int z);
		return x >= 0 && x < GRID_X_DEF && y >= 0 && y < GRID_Y_DEF &&
			z >= 0 && z < GRID_Z_DEF;
	endfunction

	function automatic int voxel_index(int x, int y, int z);
		return (x * GRID_Y_DEF + y) * GRID_Z_DEF + z;
	endfunction

	function automatic bit cell_blocked(int x, int y, int z);
		if (!on_grid(x, y, z))
			return 1'b1;
		return occ_map[voxel_index(x, y, z)];
	endfunction

	// update the mirror map and work out the result of one request
	function automatic voxel_res_t apply_request(logic act, logic signed [COORD_W-1:0] px,
		logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz, logic blk);
		voxel_res_t res;
		int cx, cy, cz, r, best, d;
		cx = int'(px);
		cy = int'(py);
		cz = int'(pz);
		res.x = px;
		res.y = py;
		res.z = pz;
		if (act == ACT_WRITE) begin
			if (on_grid(cx, cy, cz))
				occ_map[voxel_index(cx, cy, cz)] = blk;
			res.st = STAT_WRITE;
		end else begin
			r = (int'(snap_radius) > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(snap_radius);
			if (!cell_blocked(cx, cy, cz) || r == 0) begin
				res.st = STAT_KEEP;
			end else begin
				best = -1;
				// scan the cube, x outermost, first hit wins a tie
				for (int dx = -r; dx <= r; dx++)
					for (int dy = -r; dy <= r; dy++)
						for (int dz = -r; dz <= r; dz++) begin
							if (cell_blocked(cx + dx, cy + dy, cz + dz))
								continue;
							d = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) + (dz < 0 ? -dz : dz);
							if (best < 0 || d < best) begin
								best = d;
								res.x = COORD_W'(cx + dx);
								res.y = COORD_W'(cy + dy);
								res.z = COORD_W'(cz + dz);
							end
						end
				res.st = (best < 0) ? STAT_NONE : STAT_MOVED;
			end
		end
		return res;
	endfunction

	// request driver
	always @(posedge clk) begin
		voxel_req_t nxt;
		logic send;
		if (arst_n) begin
			if (in_valid && in_ready)
				expect_q.insert(expect_q.size(),
					apply_request(action, cell_x, cell_y, cell_z, block_bit));
			if (!in_valid || in_ready) begin
				send = pending_q.size() != 0 && (no_gaps || $urandom_range(99) >= 29);
				if (send) begin
					nxt = pending_q.pop_front();
					action <= nxt.act;
					cell_x <= nxt.x;
					cell_y <= nxt.y;
					cell_z <= nxt.z;
					block_bit <= nxt.blk;
				end
				in_valid <= send;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		voxel_res_t want;
		logic rdy;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expect_q.size() == 0) begin
					$error("unexpected result x=%0d y=%0d z=%0d status=%0d",
						out_x, out_y, out_z, status);
					mismatch_total++;
				end else begin
					want = expect_q.pop_front();
					status_seen[want.st]++;
					if (out_x !== want.x) begin
						$error("out_x: expected %0d, got %0d", want.x, out_x);
						mismatch_total++;
					end
					if (out_y !== want.y) begin
						$error("out_y: expected %0d, got %0d", want.y, out_y);
						mismatch_total++;
					end
					if (out_z !== want.z) begin
						$error("out_z: expected %0d, got %0d", want.z, out_z);
						mismatch_total++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						mismatch_total++;
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (hold_arm && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				rdy = no_gaps || $urandom_range(99) >= 29;
			end
			out_ready <= rdy;
		end
	end

	task automatic queue_req(logic act, int x, int y, int z, logic blk);
		voxel_req_t req;
		req.act = act;
		req.x = COORD_W'(x);
		req.y = COORD_W'(y);
		req.z = COORD_W'(z);
		req.blk = blk;
		pending_q.insert(pending_q.size(), req);
		queued_total++;
	endtask

	task automatic set_radius(logic [RADIUS_W-1:0] r);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		snap_radius = r;
		phase_count++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || expect_q.size() != 0 || in_valid);
	endtask

	// coordinate biased toward the faces of the grid
	function automatic int pick_axis(int span);
		case ($urandom_range(3))
			0: return int'($urandom_range(2));
			1: return span - 1 - int'($urandom_range(2));
			default: return int'($urandom_range(span - 1));
		endcase
	endfunction

	function automatic int jitter(int spread);
		return int'($urandom_range(2 * spread)) - spread;
	endfunction

	// blocked cluster followed by snaps into it, or a raw noise request
	task automatic queue_scene();
		int cx, cy, cz, spread;
		if ($urandom_range(3) == 0) begin
			queue_req(1'($urandom_range(1)), int'($urandom_range(95)) - 32,
				int'($urandom_range(95)) - 32, int'($urandom_range(95)) - 32,
				1'($urandom_range(1)));
		end else begin
			cx = pick_axis(GRID_X_DEF);
			cy = pick_axis(GRID_Y_DEF);
			cz = pick_axis(GRID_Z_DEF);
			spread = $urandom_range(1, 2);
			queue_req(ACT_WRITE, cx, cy, cz, 1'b1);
			repeat ($urandom_range(1, 8))
				queue_req(ACT_WRITE, cx + jitter(spread), cy + jitter(spread),
					cz + jitter(spread), 1'b1);
			if ($urandom_range(3) == 0)
				queue_req(ACT_WRITE, cx + jitter(1), cy + jitter(1), cz + jitter(1), 1'b0);
			queue_req(ACT_SNAP, cx, cy, cz, 1'($urandom_range(1)));
			if ($urandom_range(1))
				queue_req(ACT_SNAP, cx + jitter(1), cy + jitter(1), cz + jitter(1),
					1'($urandom_range(1)));
		end
	endtask

	task automatic run_phase(logic [RADIUS_W-1:0] r, int count);
		int goal;
		set_radius(r);
		goal = queued_total + count;
		while (queued_total < goal)
			queue_scene();
		wait_idle();
	endtask

	// stimulus
	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed requests at the reset radius
		queue_req(ACT_SNAP, 0, 0, 0, 1'b0);
		queue_req(ACT_WRITE, 0, 0, 0, 1'b1);
		queue_req(ACT_SNAP, 0, 0, 0, 1'b1);
		for (int i = 1; i < 8; i++)
			queue_req(ACT_WRITE, int'(i[2]), int'(i[1]), int'(i[0]), 1'b1);
		// corner walled in on all sides
		queue_req(ACT_SNAP, 0, 0, 0, 1'b0);
		// whole cube off the grid
		queue_req(ACT_SNAP, -5, -5, -5, 1'b0);
		// write off the grid leaves the map alone
		queue_req(ACT_WRITE, 63, -32, 40, 1'b1);
		queue_req(ACT_SNAP, 31, 31, 31, 1'b0);
		queue_req(ACT_WRITE, 31, 31, 31, 1'b1);
		queue_req(ACT_SNAP, 31, 31, 31, 1'b0);
		queue_req(ACT_WRITE, 0, 0, 0, 1'b0);
		queue_req(ACT_SNAP, 0, 0, 0, 1'b0);
		queue_req(ACT_SNAP, -32, 63, -32, 1'b1);
		wait_idle();

		// zero radius: blocked and off-grid cells come back as they are,
		// with the receiver held off long enough to fill the block
		set_radius(3'd0);
		queue_req(ACT_SNAP, 31, 31, 31, 1'b0);
		queue_req(ACT_SNAP, -32, 63, 5, 1'b0);
		hold_arm = 1'b1;
		begin
			int goal;
			goal = queued_total + 20;
			while (queued_total < goal)
				queue_scene();
		end
		wait_idle();

		// back-to-back traffic with no idling on either side
		no_gaps = 1'b1;
		run_phase(3'd2, 25);
		no_gaps = 1'b0;

		run_phase(3'd7, 20);
		run_phase(3'd3, 25);
		run_phase(3'd5, 20);
		run_phase(3'd1, 25);

		repeat (16) @(posedge clk);
		$display("covered %0d requests over %0d written radius settings (0 and 7 included)",
			queued_total, phase_count);
		$display("results: %0d kept, %0d moved, %0d none found, %0d writes",
			status_seen[STAT_KEEP], status_seen[STAT_MOVED], status_seen[STAT_NONE],
			status_seen[STAT_WRITE]);
		if (mismatch_total == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
hdl/nfvs_pkg.sv
hdl/nfvs_map.sv
hdl/nearest_free_voxel_snap.sv
tb/sv/nearest_free_voxel_snap_test.sv
